// ===== rtl/vbfe_pkg.sv =====
package vbfe_pkg;

    localparam int COORD_W = 5;
    localparam int SIZE_W  = 6;
    localparam int FACE_W  = 3;
    localparam int VCNT_W  = 20;
    localparam int NUM_FACES = 6;
    localparam int CFG_IDX_W = 2;

    // command codes
    localparam logic CMD_WRITE = 1'b0;
    localparam logic CMD_QUERY = 1'b1;

    // configuration register indexes
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_X = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Y = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_SIZE_Z = 2'd2;

    localparam logic [SIZE_W-1:0] SIZE_RESET = 6'd32;

    // face codes, also the emission order
    localparam logic [FACE_W-1:0] FACE_NEG_X = 3'd0;
    localparam logic [FACE_W-1:0] FACE_POS_X = 3'd1;
    localparam logic [FACE_W-1:0] FACE_NEG_Z = 3'd2;
    localparam logic [FACE_W-1:0] FACE_POS_Z = 3'd3;
    localparam logic [FACE_W-1:0] FACE_NEG_Y = 3'd4;
    localparam logic [FACE_W-1:0] FACE_POS_Y = 3'd5;

    localparam logic [VCNT_W-1:0] VERTS_PER_FACE = 20'd4;

    typedef struct packed {
        logic               cmd;
        logic [COORD_W-1:0] cell_x;
        logic [COORD_W-1:0] cell_y;
        logic [COORD_W-1:0] cell_z;
        logic               solid_in;
    } t_in;

    typedef struct packed {
        logic [FACE_W-1:0]  face_code;
        logic [COORD_W-1:0] face_x;
        logic [COORD_W-1:0] face_y;
        logic [COORD_W-1:0] face_z;
        logic [VCNT_W-1:0]  base_index;
        logic               last_face;
    } t_out;

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_READ,
        ST_EMIT
    } t_state;

endpackage

// ===== rtl/voxel_boundary_face_extract.sv =====
// Voxel boundary face extractor. Holds a one-bit solid map of a DIM_MAX^3
// voxel grid in a single synchronous RAM and answers face queries against it.
// A write transaction (cmd 0) stores one cell flag in the RAM; writes
// at a coordinate >= DIM_MAX on any axis are dropped. A query transaction
// (cmd 1) reads the cell and its six neighbors through the one RAM read port,
// one read per cycle, so a query holds the input through those reads (only the
// center read when the cell is empty or outside the size_x/y/z extent), then
// while one record per exposed face drains through the output register; a
// stalled output slows that drain. Face records come in the order
// -x, +x, -z, +z, -y, +y, carry a running 20-bit vertex base that steps by 4
// and wraps, and the final one of a query has last_face set. After reset the
// RAM is swept to empty, one cell per cycle, over all DIM_MAX^3 cells (32768 at
// the default) while the input is stalled; configuration writes are taken at
// any time, but should only be issued while the block is idle.
module voxel_boundary_face_extract #(
    parameter int DIM_MAX = 32
) (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_stall,
    input  vbfe_pkg::t_in                       i_in_data,
    output logic                                o_out_valid,
    input  logic                                i_out_stall,
    output vbfe_pkg::t_out                      o_out_data,
    input  logic                                i_cfg_valid,
    output logic                                o_cfg_ready,
    input  logic [vbfe_pkg::CFG_IDX_W-1:0]      i_cfg_index,
    input  logic [vbfe_pkg::SIZE_W-1:0]         i_cfg_data
);
    import vbfe_pkg::*;

    localparam int DEPTH = DIM_MAX * DIM_MAX * DIM_MAX;
    localparam int AW    = $clog2(DEPTH);
    // wide enough for size registers, DIM_MAX and coordinate + 1
    localparam int EW    = ($clog2(DIM_MAX + 1) > SIZE_W) ? $clog2(DIM_MAX + 1) : SIZE_W;
    localparam logic [EW-1:0] DIM_E     = EW'(DIM_MAX);
    localparam logic [AW-1:0] STEP_Z    = AW'(1);
    localparam logic [AW-1:0] STEP_Y    = AW'(DIM_MAX);
    localparam logic [AW-1:0] STEP_X    = AW'(DIM_MAX * DIM_MAX);
    localparam logic [AW-1:0] CLR_LAST  = AW'(DEPTH - 1);
    localparam logic [2:0]    TAG_CENTER = 3'd0;
    localparam logic [2:0]    TAG_LAST   = 3'(NUM_FACES);

    // x-major linear address; only constant multiplies
    function automatic logic [AW-1:0] cell_addr(input logic [COORD_W-1:0] x,
                                                input logic [COORD_W-1:0] y,
                                                input logic [COORD_W-1:0] z);
        int lin;
        lin = int'(x) * DIM_MAX * DIM_MAX + int'(y) * DIM_MAX + int'(z);
        return AW'(lin);
    endfunction

    function automatic logic [EW-1:0] extent(input logic [SIZE_W-1:0] size);
        logic [EW-1:0] s;
        s = EW'(size);
        return (s < DIM_E) ? s : DIM_E;
    endfunction

    // ------------------------------------------------------------------
    // state
    // ------------------------------------------------------------------
    t_state               r_state, n_state;
    logic [SIZE_W-1:0]    r_size_x, r_size_y, r_size_z;
    logic [AW-1:0]        r_clr_addr, n_clr_addr;
    logic [COORD_W-1:0]   r_cx, r_cy, r_cz, n_cx, n_cy, n_cz;
    logic [AW-1:0]        r_addr, n_addr;
    logic [2:0]           r_tag, n_tag;          // which RAM read is in r_rdata
    logic [NUM_FACES-1:0] r_mask, n_mask;        // exposed faces still to emit
    logic [VCNT_W-1:0]    r_vcnt, n_vcnt;
    logic                 r_out_valid, n_out_valid;
    t_out                 r_out, n_out;
    logic                 r_rdata;

    logic                 mem [DEPTH];
    logic                 mem_we;
    logic [AW-1:0]        mem_wa;
    logic                 mem_wd;
    logic [AW-1:0]        mem_ra;

    logic                 in_acc;
    logic                 wr_in_range;
    logic [EW-1:0]        ex, ey, ez;
    logic [EW-1:0]        cx_e, cy_e, cz_e;
    logic                 center_in;
    logic [2:0]           chk_face;
    logic                 nb_in;
    logic [AW-1:0]        nb_addr;
    logic [FACE_W-1:0]    sel_face;
    logic [NUM_FACES-1:0] sel_onehot;

    assign o_in_stall  = (r_state != ST_IDLE);
    assign in_acc      = i_in_valid && !o_in_stall;
    assign o_cfg_ready = 1'b1;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;

    // effective grid extent per axis
    assign ex   = extent(r_size_x);
    assign ey   = extent(r_size_y);
    assign ez   = extent(r_size_z);
    assign cx_e = EW'(r_cx);
    assign cy_e = EW'(r_cy);
    assign cz_e = EW'(r_cz);

    assign center_in   = (cx_e < ex) && (cy_e < ey) && (cz_e < ez);
    assign wr_in_range = (EW'(i_in_data.cell_x) < DIM_E) &&
                         (EW'(i_in_data.cell_y) < DIM_E) &&
                         (EW'(i_in_data.cell_z) < DIM_E);

    // neighbor whose read result is in r_rdata (tag 1..6 -> face 0..5)
    assign chk_face = r_tag - 3'd1;

    always_comb begin
        case (chk_face)
            FACE_NEG_X: nb_in = (r_cx != '0);
            FACE_POS_X: nb_in = ((cx_e + EW'(1)) < ex);
            FACE_NEG_Z: nb_in = (r_cz != '0);
            FACE_POS_Z: nb_in = ((cz_e + EW'(1)) < ez);
            FACE_NEG_Y: nb_in = (r_cy != '0);
            FACE_POS_Y: nb_in = ((cy_e + EW'(1)) < ey);
            default:    nb_in = 1'b0;
        endcase
    end

    // address of the neighbor read issued this cycle (face = r_tag);
    // wraps harmlessly when the neighbor is off-grid, nb_in masks it
    always_comb begin
        case (r_tag)
            FACE_NEG_X: nb_addr = r_addr - STEP_X;
            FACE_POS_X: nb_addr = r_addr + STEP_X;
            FACE_NEG_Z: nb_addr = r_addr - STEP_Z;
            FACE_POS_Z: nb_addr = r_addr + STEP_Z;
            FACE_NEG_Y: nb_addr = r_addr - STEP_Y;
            FACE_POS_Y: nb_addr = r_addr + STEP_Y;
            default:    nb_addr = r_addr;
        endcase
    end

    // lowest pending face goes out first
    always_comb begin
        sel_face = FACE_NEG_X;
        for (int f = NUM_FACES - 1; f >= 0; f--) begin
            if (r_mask[f]) begin
                sel_face = 3'(f);
            end
        end
        sel_onehot = NUM_FACES'(1) << sel_face;
    end

    // ------------------------------------------------------------------
    // next state
    // ------------------------------------------------------------------
    always_comb begin
        n_state     = r_state;
        n_clr_addr  = r_clr_addr;
        n_cx        = r_cx;
        n_cy        = r_cy;
        n_cz        = r_cz;
        n_addr      = r_addr;
        n_tag       = r_tag;
        n_mask      = r_mask;
        n_vcnt      = r_vcnt;
        n_out       = r_out;
        n_out_valid = r_out_valid && i_out_stall;

        case (r_state)
            ST_CLEAR: begin
                n_clr_addr = r_clr_addr + AW'(1);
                if (r_clr_addr == CLR_LAST) begin
                    n_state = ST_IDLE;
                end
            end
            ST_IDLE: begin
                if (in_acc && (i_in_data.cmd == CMD_QUERY)) begin
                    n_state = ST_READ;
                    n_tag   = TAG_CENTER;
                    n_mask  = '0;
                    n_cx    = i_in_data.cell_x;
                    n_cy    = i_in_data.cell_y;
                    n_cz    = i_in_data.cell_z;
                    n_addr  = cell_addr(i_in_data.cell_x, i_in_data.cell_y,
                                        i_in_data.cell_z);
                end
            end
            ST_READ: begin
                if (r_tag == TAG_CENTER) begin
                    // empty or off-grid cell: no faces
                    if (!(center_in && r_rdata)) begin
                        n_state = ST_IDLE;
                    end else begin
                        n_tag = r_tag + 3'd1;
                    end
                end else begin
                    n_mask[chk_face] = !(nb_in && r_rdata);
                    if (r_tag == TAG_LAST) begin
                        n_state = (n_mask != '0) ? ST_EMIT : ST_IDLE;
                    end else begin
                        n_tag = r_tag + 3'd1;
                    end
                end
            end
            ST_EMIT: begin
                if (!r_out_valid || !i_out_stall) begin
                    n_out_valid      = 1'b1;
                    n_mask           = r_mask & ~sel_onehot;
                    n_out.face_code  = sel_face;
                    n_out.face_x     = r_cx;
                    n_out.face_y     = r_cy;
                    n_out.face_z     = r_cz;
                    n_out.base_index = r_vcnt;
                    n_out.last_face  = (n_mask == '0);
                    n_vcnt           = r_vcnt + VERTS_PER_FACE;
                    if (n_mask == '0) begin
                        n_state = ST_IDLE;
                    end
                end
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // ------------------------------------------------------------------
    // RAM port control
    // ------------------------------------------------------------------
    always_comb begin
        mem_we = 1'b0;
        mem_wa = cell_addr(i_in_data.cell_x, i_in_data.cell_y, i_in_data.cell_z);
        mem_wd = i_in_data.solid_in;
        mem_ra = nb_addr;
        case (r_state)
            ST_CLEAR: begin
                mem_we = 1'b1;
                mem_wa = r_clr_addr;
                mem_wd = 1'b0;
            end
            ST_IDLE: begin
                // center read issued speculatively on every idle cycle
                mem_ra = cell_addr(i_in_data.cell_x, i_in_data.cell_y,
                                   i_in_data.cell_z);
                mem_we = in_acc && (i_in_data.cmd == CMD_WRITE) && wr_in_range;
            end
            ST_READ: begin
                mem_ra = nb_addr;
            end
            default: begin
                mem_ra = nb_addr;
            end
        endcase
    end

    // write and read never hit the same cycle outside idle/clear, so a query
    // right after a write sees the written flag without forwarding
    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            mem[mem_wa] <= mem_wd;
        end
        r_rdata <= mem[mem_ra];
    end

    // ------------------------------------------------------------------
    // registers
    // ------------------------------------------------------------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr_addr  <= '0;
            r_tag       <= TAG_CENTER;
            r_mask      <= '0;
            r_vcnt      <= '0;
            r_out_valid <= 1'b0;
            r_size_x    <= SIZE_RESET;
            r_size_y    <= SIZE_RESET;
            r_size_z    <= SIZE_RESET;
        end else begin
            r_state     <= n_state;
            r_clr_addr  <= n_clr_addr;
            r_tag       <= n_tag;
            r_mask      <= n_mask;
            r_vcnt      <= n_vcnt;
            r_out_valid <= n_out_valid;
            if (i_cfg_valid && o_cfg_ready) begin
                case (i_cfg_index)
                    REG_SIZE_X: r_size_x <= i_cfg_data;
                    REG_SIZE_Y: r_size_y <= i_cfg_data;
                    REG_SIZE_Z: r_size_z <= i_cfg_data;
                    default:    r_size_x <= r_size_x;
                endcase
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_cx   <= n_cx;
        r_cy   <= n_cy;
        r_cz   <= n_cz;
        r_addr <= n_addr;
        r_out  <= n_out;
    end

endmodule

// ===== rtl/vbfe_checker.sv =====
module vbfe_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           o_in_stall,
    input logic                           o_out_valid,
    input logic                           i_out_stall,
    input vbfe_pkg::t_out                 o_out_data
);
    import vbfe_pkg::*;

    // a stalled record stays offered
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid && i_out_stall |=> o_out_valid)
        else $error("output record dropped while stalled");

    // vertex bases are quad aligned
    a_base_align: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.base_index[1:0] == 2'b00))
        else $error("base_index not a multiple of 4");

    // only the six face codes are emitted
    a_face_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_out_valid |-> (o_out_data.face_code <= FACE_POS_Y))
        else $error("face_code out of range");

    // a record offered right after a taken one is the next quad
    a_base_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_stall) ##1 o_out_valid |->
        (o_out_data.base_index ==
         VCNT_W'($past(o_out_data.base_index) + VERTS_PER_FACE)))
        else $error("base_index did not advance by one quad");

    // input stays stalled through reset and into the clear sweep
    a_rst_stall: assert property (@(posedge i_clk)
        !i_rst_n |=> o_in_stall)
        else $error("input accepted during RAM clear");

endmodule

bind voxel_boundary_face_extract vbfe_checker u_vbfe_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .o_in_stall  (o_in_stall),
    .o_out_valid (o_out_valid),
    .i_out_stall (i_out_stall),
    .o_out_data  (o_out_data)
);

// ===== dv/voxel_boundary_face_extract_test.sv =====
`timescale 1ns / 1ps

module voxel_boundary_face_extract_test;
    import vbfe_pkg::*;

    localparam int GRID        = 32;      // DIM_MAX of the instance
    localparam int QUIET_LIMIT = 100000;  // covers the post-reset clear sweep several times
    localparam int SETTLE      = 16;      // covers the busy tail of a no-face query
    localparam int HOLD_CYCLES = 400;     // long receiver hold-off
    localparam int PHASE_ITEMS = 24;
    localparam int STREAM_QUERIES = 4;

    // one row of the directed plan: the transaction, and where the answer is
    // obvious, the exposed-face mask typed in (bit n = face code n)
    typedef struct packed {
        t_in                  item;
        logic                 typed;
        logic [NUM_FACES-1:0] faces;
    } t_row;

    localparam int PLAN_LEN = 24;
    localparam t_row PLAN [PLAN_LEN] = '{
        // fresh map: everything is empty
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd31, 5'd31, 5'd31, 1'b1}, 1'b1, 6'b000000},
        // lone corner cells show all six faces
        '{'{CMD_WRITE, 5'd0,  5'd0,  5'd0,  1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b111111},
        '{'{CMD_WRITE, 5'd31, 5'd31, 5'd31, 1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd31, 5'd31, 5'd31, 1'b0}, 1'b1, 6'b111111},
        // +x neighbor hides one face on each side
        '{'{CMD_WRITE, 5'd1,  5'd0,  5'd0,  1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd0,  1'b1}, 1'b1, 6'b111101},
        '{'{CMD_QUERY, 5'd1,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b111110},
        // low corner boxed in on the + sides: only -x, -z, -y remain
        '{'{CMD_WRITE, 5'd0,  5'd0,  5'd1,  1'b1}, 1'b1, 6'b000000},
        '{'{CMD_WRITE, 5'd0,  5'd1,  5'd0,  1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b010101},
        // clearing a cell turns its query silent
        '{'{CMD_WRITE, 5'd0,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd0,  1'b0}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd0,  5'd0,  5'd1,  1'b0}, 1'b0, 6'b000000},
        // high corner boxed in on the - sides: only +x, +z, +y remain
        '{'{CMD_WRITE, 5'd30, 5'd31, 5'd31, 1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd31, 5'd31, 5'd31, 1'b0}, 1'b1, 6'b111110},
        '{'{CMD_WRITE, 5'd31, 5'd30, 5'd31, 1'b1}, 1'b1, 6'b000000},
        '{'{CMD_WRITE, 5'd31, 5'd31, 5'd30, 1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd31, 5'd31, 5'd31, 1'b1}, 1'b1, 6'b101010},
        '{'{CMD_QUERY, 5'd30, 5'd31, 5'd31, 1'b0}, 1'b0, 6'b000000},
        // alternating coordinate bits
        '{'{CMD_WRITE, 5'd21, 5'd10, 5'd21, 1'b1}, 1'b1, 6'b000000},
        '{'{CMD_QUERY, 5'd21, 5'd10, 5'd21, 1'b0}, 1'b1, 6'b111111},
        '{'{CMD_QUERY, 5'd10, 5'd21, 5'd10, 1'b1}, 1'b1, 6'b000000}
    };

    logic                 clk       = 1'b0;
    logic                 rst_n     = 1'b0;
    logic                 in_valid  = 1'b0;
    logic                 in_stall;
    t_in                  in_data   = '0;
    logic                 out_valid;
    logic                 out_stall = 1'b0;
    t_out                 out_data;
    logic                 cfg_valid = 1'b0;
    logic                 cfg_ready;
    logic [CFG_IDX_W-1:0] cfg_index = REG_SIZE_X;
    logic [SIZE_W-1:0]    cfg_data  = '0;

    // shadow of the block: cell map, vertex counter, size registers
    bit                solid_shadow [GRID*GRID*GRID];
    logic [VCNT_W-1:0] vtx_base;
    logic [SIZE_W-1:0] size_x_r, size_y_r, size_z_r;

    t_out pending_faces [$];   // face records still owed by the block
    t_out want;
    int   errors          = 0;
    int   faces_predicted = 0;
    bit   idle_on         = 1'b1;
    int   hold_asked      = 0;
    int   hold_seen       = 0;
    int   stall_left      = 0;
    int   quiet           = 0;

    always begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    voxel_boundary_face_extract #(
        .DIM_MAX(GRID)
    ) dut (
        .i_clk      (clk),
        .i_rst_n    (rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data),
        .i_cfg_valid(cfg_valid),
        .o_cfg_ready(cfg_ready),
        .i_cfg_index(cfg_index),
        .i_cfg_data (cfg_data)
    );

    //------------------------------------------------------------------
    // Face prediction
    //------------------------------------------------------------------

    // usable extent along one axis: size register clipped to the storage
    function automatic int extent(logic [SIZE_W-1:0] s);
        return (s > GRID) ? GRID : int'(s);
    endfunction

    // anything off the grid reads as empty, so its shared face shows
    function automatic bit solid_at(int x, int y, int z);
        if (x < 0 || y < 0 || z < 0)
            return 1'b0;
        if (x >= extent(size_x_r) || y >= extent(size_y_r) || z >= extent(size_z_r))
            return 1'b0;
        return solid_shadow[(x * GRID + y) * GRID + z];
    endfunction

    // bit n set when face code n of the queried cell is exposed; all zero
    // when the cell is empty or off the grid
    function automatic logic [NUM_FACES-1:0] exposed_faces(t_in it);
        logic [NUM_FACES-1:0] m;
        int x, y, z;
        m = '0;
        x = int'(it.cell_x);
        y = int'(it.cell_y);
        z = int'(it.cell_z);
        if (solid_at(x, y, z)) begin
            for (int f = 0; f < NUM_FACES; f++) begin
                case (FACE_W'(f))
                    FACE_NEG_X: m[f] = !solid_at(x - 1, y, z);
                    FACE_POS_X: m[f] = !solid_at(x + 1, y, z);
                    FACE_NEG_Z: m[f] = !solid_at(x, y, z - 1);
                    FACE_POS_Z: m[f] = !solid_at(x, y, z + 1);
                    FACE_NEG_Y: m[f] = !solid_at(x, y - 1, z);
                    FACE_POS_Y: m[f] = !solid_at(x, y + 1, z);
                    default:    m[f] = 1'b0;
                endcase
            end
        end
        return m;
    endfunction

    // Apply one accepted transaction to the shadow and queue the face records
    // it owes. A typed row supplies its own face mask.
    task automatic predict_faces(t_in it, logic typed, logic [NUM_FACES-1:0] typed_mask);
        logic [NUM_FACES-1:0] m;
        t_out rec;
        int   final_face;
        if (it.cmd == CMD_WRITE) begin
            solid_shadow[(int'(it.cell_x) * GRID + int'(it.cell_y)) * GRID
                         + int'(it.cell_z)] = it.solid_in;
        end else begin
            m = typed ? typed_mask : exposed_faces(it);
            final_face = -1;
            for (int f = 0; f < NUM_FACES; f++)
                if (m[f])
                    final_face = f;
            for (int f = 0; f < NUM_FACES; f++) begin
                if (m[f]) begin
                    rec.face_code  = FACE_W'(f);
                    rec.face_x     = it.cell_x;
                    rec.face_y     = it.cell_y;
                    rec.face_z     = it.cell_z;
                    rec.base_index = vtx_base;
                    rec.last_face  = (f == final_face);
                    pending_faces  = {pending_faces, rec};
                    vtx_base = vtx_base + VERTS_PER_FACE;   // wraps at 20 bits
                    faces_predicted++;
                end
            end
        end
    endtask

    //------------------------------------------------------------------
    // Input side
    //------------------------------------------------------------------

    // Offer one transaction after a random gap and hold it until taken.
    // With no gap valid simply stays high and only the payload changes.
    task automatic send_cell(t_in it, logic typed, logic [NUM_FACES-1:0] mask);
        int gap;
        gap = idle_on ? $urandom_range(0, 11) : 0;
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall !== 1'b0);
        predict_faces(it, typed, mask);
    endtask

    // stop offering and wait out every owed record plus the busy tail of
    // a silent query
    task automatic drain();
        in_valid <= 1'b0;
        while (pending_faces.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    // back-to-back writes of all three size registers; valid stays high
    task automatic set_sizes(logic [SIZE_W-1:0] sx, logic [SIZE_W-1:0] sy,
                             logic [SIZE_W-1:0] sz);
        logic [SIZE_W-1:0]    vals [3];
        logic [CFG_IDX_W-1:0] regs [3];
        vals = '{sx, sy, sz};
        regs = '{REG_SIZE_X, REG_SIZE_Y, REG_SIZE_Z};
        cfg_valid <= 1'b1;
        for (int i = 0; i < 3; i++) begin
            cfg_index <= regs[i];
            cfg_data  <= vals[i];
            do @(posedge clk); while (cfg_ready !== 1'b1);
            case (regs[i])
                REG_SIZE_X: size_x_r = vals[i];
                REG_SIZE_Y: size_y_r = vals[i];
                REG_SIZE_Z: size_z_r = vals[i];
                default: ;
            endcase
        end
        cfg_valid <= 1'b0;
    endtask

    // cluster corner so that the window of four touches the upper extent
    function automatic int pick_origin(logic [SIZE_W-1:0] s);
        int e;
        e = extent(s);
        return (e > 3) ? int'($urandom_range(0, e - 3)) : 0;
    endfunction

    // mostly inside a small cluster so neighbors collide; some walls and noise
    function automatic logic [COORD_W-1:0] pick_coord(int org);
        int v;
        case ($urandom_range(0, 9))
            0:       v = 0;
            1:       v = GRID - 1;
            2:       v = $urandom_range(0, GRID - 1);
            default: v = org + $urandom_range(0, 3);
        endcase
        return COORD_W'((v > GRID - 1) ? GRID - 1 : v);
    endfunction

    function automatic t_in rand_cell(int ox, int oy, int oz);
        t_in it;
        it.cmd      = ($urandom_range(0, 99) < 45) ? CMD_WRITE : CMD_QUERY;
        it.cell_x   = pick_coord(ox);
        it.cell_y   = pick_coord(oy);
        it.cell_z   = pick_coord(oz);
        it.solid_in = ($urandom_range(0, 3) != 0);
        return it;
    endfunction

    task automatic run_phase(int count, bit pressure);
        int ox, oy, oz;
        ox = pick_origin(size_x_r);
        oy = pick_origin(size_y_r);
        oz = pick_origin(size_z_r);
        for (int i = 0; i < count; i++) begin
            // receiver freezes while the sender keeps offering, so the
            // block backs up and stalls its input
            if (pressure && i == 2)
                hold_asked++;
            send_cell(rand_cell(ox, oy, oz), 1'b0, '0);
        end
    endtask

    //------------------------------------------------------------------
    // Output side: per-record stall draw, plus the long hold-off on request
    //------------------------------------------------------------------
    always @(posedge clk) begin
        if (hold_seen != hold_asked) begin
            hold_seen  = hold_asked;
            stall_left = HOLD_CYCLES;
        end else if (out_valid === 1'b1 && !out_stall) begin
            stall_left = idle_on ? $urandom_range(0, 11) : 0;
        end
        if (stall_left > 0) begin
            out_stall <= 1'b1;
            stall_left--;
        end else begin
            out_stall <= 1'b0;
        end
    end

    task automatic check_field(string name, longint unsigned exp_v, longint unsigned act_v);
        if (exp_v != act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
        end
    endtask

    // every accepted record against the oldest owed one
    always @(posedge clk) begin
        if (rst_n && out_valid === 1'b1 && !out_stall) begin
            if (pending_faces.size() == 0) begin
                $error("face record with none owed: %h", out_data);
                errors++;
            end else begin
                want = pending_faces.pop_front();
                check_field("face_code",  want.face_code,  out_data.face_code);
                check_field("face_x",     want.face_x,     out_data.face_x);
                check_field("face_y",     want.face_y,     out_data.face_y);
                check_field("face_z",     want.face_z,     out_data.face_z);
                check_field("base_index", want.base_index, out_data.base_index);
                check_field("last_face",  want.last_face,  out_data.last_face);
            end
        end
    end

    // watchdog: too long without any transaction on any channel
    always @(posedge clk) begin
        if ((in_valid && in_stall === 1'b0) || (out_valid === 1'b1 && !out_stall) ||
            (cfg_valid && cfg_ready === 1'b1))
            quiet = 0;
        else
            quiet++;
        if (quiet >= QUIET_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    //------------------------------------------------------------------
    // Sequence
    //------------------------------------------------------------------
    initial begin
        int size_plan [8][3];
        int rand_start;
        t_in probe;

        vtx_base = '0;
        size_x_r = SIZE_RESET;
        size_y_r = SIZE_RESET;
        size_z_r = SIZE_RESET;
        size_plan = '{'{32, 32, 32}, '{1, 1, 1}, '{0, 5, 63}, '{63, 63, 63},
                      '{7, 32, 3}, '{4, 4, 4}, '{0, 0, 0}, '{0, 0, 0}};

        repeat (8) @(posedge clk);
        rst_n <= 1'b1;

        // directed plan at reset sizes; the first transaction waits out the
        // clear sweep behind the input stall
        for (int i = 0; i < PLAN_LEN; i++)
            send_cell(PLAN[i].item, PLAN[i].typed, PLAN[i].faces);

        // random phases over several grid shapes, extremes included; the
        // last two shapes are drawn at random
        rand_start = faces_predicted;
        for (int p = 0; p < 8; p++) begin
            drain();
            if (p >= 6)
                set_sizes(SIZE_W'($urandom_range(0, 63)), SIZE_W'($urandom_range(0, 63)),
                          SIZE_W'($urandom_range(0, 63)));
            else
                set_sizes(SIZE_W'(size_plan[p][0]), SIZE_W'(size_plan[p][1]),
                          SIZE_W'(size_plan[p][2]));
            idle_on = (p % 3 != 2) && (p != 5);
            run_phase(PHASE_ITEMS, p == 5);
        end
        // top up on a dense small grid if faces were scarce
        while (faces_predicted - rand_start < 48) begin
            drain();
            set_sizes(SIZE_W'(4), SIZE_W'(4), SIZE_W'(4));
            idle_on = 1'b1;
            run_phase(20, 1'b0);
        end

        // one-cell grid, every query shows six faces, streamed with no
        // idling on either side
        drain();
        set_sizes(SIZE_W'(1), SIZE_W'(1), SIZE_W'(1));
        idle_on = 1'b0;
        probe = '{CMD_WRITE, 5'd0, 5'd0, 5'd0, 1'b1};
        send_cell(probe, 1'b0, '0);
        probe.cmd = CMD_QUERY;
        repeat (STREAM_QUERIES) send_cell(probe, 1'b0, '0);

        drain();
        if (errors == 0)
            $display("status: pass");
        else
            $display("status: fail");
        $finish;
    end

endmodule
